>>> hdl/spmf_pkg.sv
// shared types, sizes and codes of the strict priority multi-level queue
`timescale 1ns / 1ps
package spmf_pkg;

    localparam int MAX_LEVELS  = 8;
    localparam int LEVEL_DEPTH = 16;
    localparam int ITEM_WIDTH  = 32;

    localparam int SLOTS   = MAX_LEVELS * LEVEL_DEPTH;
    localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PTR_W   = $clog2(LEVEL_DEPTH);
    localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int TOTAL_W = $clog2(SLOTS + 1);
    localparam int ADDR_W  = $clog2(SLOTS);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register indexes
    localparam logic REG_LEVELS_IN_USE = 1'b0;
    localparam logic [3:0] LEVELS_RESET = 4'd8;

    // operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_EMPTY_OPEN   = 3'd1;
    localparam logic [2:0] ST_EMPTY_CLOSED = 3'd2;
    localparam logic [2:0] ST_DROP_CLOSED  = 3'd3;
    localparam logic [2:0] ST_DROP_FULL    = 3'd4;

    typedef struct packed {
        logic [1:0]        op;
        logic [31:0]       payload;
        logic signed [7:0] priority_req;
    } req_t;

    typedef struct packed {
        logic        item_valid;
        logic [31:0] item_out;
        logic [2:0]  status;
        logic [7:0]  total_count;
    } rsp_t;

    // slot memory access issued by the control stage
    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [ITEM_WIDTH-1:0] wr_data;
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
    } ram_req_t;

    // per-item result fields waiting for the slot read
    typedef struct packed {
        logic       pop_ok;
        logic [2:0] status;
        logic [7:0] total_count;
    } meta_t;

endpackage

>>> hdl/spmf_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module spmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/spmf_ctrl.sv
// level bookkeeping: clamp, priority encode, pointer and count update
`timescale 1ns / 1ps
module spmf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_fire,
    input  spmf_pkg::req_t    req,
    input  logic [3:0]        levels_in_use,
    output spmf_pkg::ram_req_t ram_req,
    output spmf_pkg::meta_t   meta
);
    import spmf_pkg::*;

    logic [CNT_W-1:0]   count_reg [MAX_LEVELS];
    logic [CNT_W-1:0]   count_next [MAX_LEVELS];
    logic [PTR_W-1:0]   head_reg [MAX_LEVELS];
    logic [PTR_W-1:0]   head_next [MAX_LEVELS];
    logic [PTR_W-1:0]   tail_reg [MAX_LEVELS];
    logic [PTR_W-1:0]   tail_next [MAX_LEVELS];
    logic [TOTAL_W-1:0] held_reg, held_next;
    logic               closed_reg, closed_next;
    meta_t              meta_reg, meta_next;

    logic [LVL_W-1:0] top_lvl, push_lvl, pop_lvl, sel_lvl;
    logic             pop_found;
    logic [CNT_W-1:0] sel_cnt;
    logic [PTR_W-1:0] sel_head, sel_tail, sel_ptr_inc;

    always_comb begin
        // highest usable level from the register
        if (levels_in_use == 4'd0) begin
            top_lvl = '0;
        end else if (int'(levels_in_use) > MAX_LEVELS) begin
            top_lvl = LVL_W'(MAX_LEVELS - 1);
        end else begin
            top_lvl = LVL_W'(levels_in_use - 4'd1);
        end

        if (req.priority_req[7]) begin
            push_lvl = '0;
        end else if (int'(req.priority_req[6:0]) > int'(top_lvl)) begin
            push_lvl = top_lvl;
        end else begin
            push_lvl = LVL_W'(req.priority_req[6:0]);
        end

        // ascending scan, last hit is the highest non-empty level
        pop_found = 1'b0;
        pop_lvl   = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (count_reg[i] != '0) begin
                pop_found = 1'b1;
                pop_lvl   = LVL_W'(i);
            end
        end

        sel_lvl  = (req.op == OP_POP) ? pop_lvl : push_lvl;
        sel_cnt  = count_reg[sel_lvl];
        sel_head = head_reg[sel_lvl];
        sel_tail = tail_reg[sel_lvl];
        sel_ptr_inc = (req.op == OP_POP) ? sel_head : sel_tail;
        if (sel_ptr_inc == PTR_W'(LEVEL_DEPTH - 1)) begin
            sel_ptr_inc = '0;
        end else begin
            sel_ptr_inc = sel_ptr_inc + 1'b1;
        end
    end

    always_comb begin
        count_next  = count_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        held_next   = held_reg;
        closed_next = closed_reg;
        ram_req     = '0;
        ram_req.wr_addr = ADDR_W'(int'(sel_lvl) * LEVEL_DEPTH + int'(sel_tail));
        ram_req.wr_data = ITEM_WIDTH'(req.payload);
        ram_req.rd_addr = ADDR_W'(int'(sel_lvl) * LEVEL_DEPTH + int'(sel_head));
        // held item keeps its fields until a new one arrives
        meta_next        = meta_reg;

        if (req_fire) begin
            meta_next.pop_ok = 1'b0;
            meta_next.status = ST_OK;
            case (req.op)
                OP_PUSH: begin
                    if (closed_reg) begin
                        meta_next.status = ST_DROP_CLOSED;
                    end else if (int'(sel_cnt) >= LEVEL_DEPTH) begin
                        meta_next.status = ST_DROP_FULL;
                    end else begin
                        ram_req.wr_en       = 1'b1;
                        tail_next[sel_lvl]  = sel_ptr_inc;
                        count_next[sel_lvl] = sel_cnt + 1'b1;
                        held_next           = held_reg + 1'b1;
                    end
                end
                OP_POP: begin
                    if (!pop_found) begin
                        meta_next.status = closed_reg ? ST_EMPTY_CLOSED : ST_EMPTY_OPEN;
                    end else begin
                        ram_req.rd_en       = 1'b1;
                        meta_next.pop_ok    = 1'b1;
                        head_next[sel_lvl]  = sel_ptr_inc;
                        count_next[sel_lvl] = sel_cnt - 1'b1;
                        held_next           = held_reg - 1'b1;
                    end
                end
                OP_CLOSE: begin
                    closed_next = 1'b1;
                end
                default: begin
                end
            endcase
            meta_next.total_count = 8'(held_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
            end
            held_reg   <= '0;
            closed_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            held_reg   <= held_next;
            closed_reg <= closed_next;
        end
    end

    always_ff @(posedge aclk) begin
        meta_reg <= meta_next;
    end

    assign meta = meta_reg;

endmodule

>>> hdl/strict_priority_multi_fifo.sv
// top level of the strict priority multi-level queue
`timescale 1ns / 1ps
// usage
// - s_ channel takes one request item per cycle: push, pop or close, with
//   payload and signed priority; the push priority is clamped into the
//   active level range set by levels_in_use (apb register at byte 0)
// - m_ channel returns exactly one result item per request: popped word,
//   status code and the number of words held after that request
// - pops take the oldest word of the highest non-empty level, including
//   levels above a lowered levels_in_use
// - a request's control stage update and slot read are registered when it
//   is accepted; its result then moves into the result reg once that is
//   free and shows on m_
// - throughput: one item every cycle while m_ready is high; the slot ram
//   has one write and one read port; a request uses at most one of them
// - when the receiver stalls, the result register and the control stage
//   both fill, then s_ready drops; no item is lost or repeated
// - reset (aresetn low, synchronous) empties all levels, reopens the queue
//   and sets levels_in_use to 8; slot contents are not cleared
module strict_priority_multi_fifo (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  spmf_pkg::req_t                     s_data,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output spmf_pkg::rsp_t                     m_data,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [spmf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [spmf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [spmf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import spmf_pkg::*;

    logic [3:0] levels_reg;
    logic       s_fire;
    logic       p1_valid_reg, p1_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       p1_advance;
    rsp_t       out_reg, out_next;
    ram_req_t   ram_req;
    meta_t      meta;
    logic [ITEM_WIDTH-1:0] rd_data;

    // config register, word index is paddr[2]
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LEVELS_IN_USE) ?
                    APB_DATA_W'(levels_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= LEVELS_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_LEVELS_IN_USE) begin
            levels_reg <= pwdata[3:0];
        end
    end

    // stage 1 moves into the result register when that one is free
    assign p1_advance = p1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !p1_valid_reg || p1_advance;
    assign s_fire     = s_valid && s_ready;

    spmf_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req_fire      (s_fire),
        .req           (s_data),
        .levels_in_use (levels_reg),
        .ram_req       (ram_req),
        .meta          (meta)
    );

    // slot store, one region of LEVEL_DEPTH words per level
    spmf_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (SLOTS)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_fire) begin
            p1_valid_next = 1'b1;
        end else if (p1_advance) begin
            p1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (p1_advance) begin
            out_valid_next       = 1'b1;
            out_next.item_valid  = meta.pop_ok;
            out_next.item_out    = meta.pop_ok ? 32'(rd_data) : 32'd0;
            out_next.status      = meta.status;
            out_next.total_count = meta.total_count;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
